FILE: rtl/osf_pkg.sv
// Shared types, constants and escape-string tables for the overstrike font filter.
package osf_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LANDSCAPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARTRIDGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLANTED   = 2'd2;

    localparam logic [7:0] ESC_CODE      = 8'h1B;
    localparam logic [7:0] BS_CODE       = 8'h08;
    localparam logic [7:0] UNDERSCORE    = 8'h5F;
    localparam logic [7:0] APOSTROPHE    = 8'h27;
    localparam logic [7:0] BACKQUOTE     = 8'h60;
    localparam logic [7:0] SLANTED_APOS  = 8'hA8;
    localparam logic [7:0] GRAVE_ACCENT  = 8'hA9;

    typedef enum logic [1:0] {
        FONT_ROMAN  = 2'd0,
        FONT_BOLD   = 2'd1,
        FONT_ITALIC = 2'd2
    } font_t;

    typedef enum logic [1:0] {
        PH_NONE    = 2'd0,
        PH_CHAR    = 2'd1,
        PH_CHAR_BS = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ESC_NONE            = 3'd0,
        ESC_ITALIC_CART     = 3'd1,
        ESC_ITALIC_PLAIN    = 3'd2,
        ESC_BOLD_CART       = 3'd3,
        ESC_BOLD_PLAIN      = 3'd4,
        ESC_ROMAN_CART      = 3'd5,
        ESC_ROMAN_CART_LAND = 3'd6,
        ESC_ROMAN_PLAIN     = 3'd7
    } esc_t;

    typedef enum logic [1:0] {
        BODY_CHAR        = 2'd0,
        BODY_CHAR_BS     = 2'd1,
        BODY_STRIKE_PORT = 2'd2,
        BODY_STRIKE_LAND = 2'd3
    } body_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_ESC  = 2'd1,
        BK_BODY = 2'd2
    } bk_state_t;

    typedef struct packed {
        esc_t       esc;
        body_t      body;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic landscape;
        logic cartridge_present;
        logic slanted_apostrophe;
    } cfg_t;

    // Index of the final byte of each font escape run.
    function automatic logic [3:0] esc_last_idx(esc_t esc);
        logic [3:0] n;
        unique case (esc)
            ESC_ITALIC_CART:     n = 4'd7;
            ESC_ITALIC_PLAIN:    n = 4'd8;
            ESC_BOLD_CART:       n = 4'd15;
            ESC_BOLD_PLAIN:      n = 4'd8;
            ESC_ROMAN_CART:      n = 4'd6;
            ESC_ROMAN_CART_LAND: n = 4'd10;
            ESC_ROMAN_PLAIN:     n = 4'd8;
            default:             n = 4'd0;
        endcase
        return n;
    endfunction

    // Strings are left-aligned in a 16-byte field, byte 0 at the top.
    function automatic logic [7:0] esc_byte(esc_t esc, logic [3:0] idx);
        logic [127:0] s;
        unique case (esc)
            ESC_ITALIC_CART:     s = {ESC_CODE, "(s1s-1B", 64'h0};
            ESC_ITALIC_PLAIN:    s = {ESC_CODE, "(s0B", ESC_CODE, "&dD", 56'h0};
            ESC_BOLD_CART:       s = {ESC_CODE, "&d@", ESC_CODE, "(s4B", ESC_CODE, "(s0s1B"};
            ESC_BOLD_PLAIN:      s = {ESC_CODE, "&d@", ESC_CODE, "(s4B", 56'h0};
            ESC_ROMAN_CART:      s = {ESC_CODE, "(s0s0B", 72'h0};
            ESC_ROMAN_CART_LAND: s = {ESC_CODE, "(s0s0B", ESC_CODE, "&d@", 40'h0};
            ESC_ROMAN_PLAIN:     s = {ESC_CODE, "(s0B", ESC_CODE, "&d@", 56'h0};
            default:             s = '0;
        endcase
        return s[{4'd15 - idx, 3'b000} +: 8];
    endfunction

    function automatic logic [4:0] body_last_idx(body_t body);
        logic [4:0] n;
        unique case (body)
            BODY_CHAR:        n = 5'd0;
            BODY_CHAR_BS:     n = 5'd1;
            BODY_STRIKE_PORT: n = 5'd19;
            BODY_STRIKE_LAND: n = 5'd19;
        endcase
        return n;
    endfunction

    // A double strike prints the char, steps back, nudges right, prints it again and nudges back.
    function automatic logic [7:0] body_byte(body_t body, logic [4:0] idx, logic [7:0] ch);
        logic [159:0] s;
        logic [7:0]   d;
        d = (body == BODY_STRIKE_LAND) ? "7" : "8";
        unique case (body)
            BODY_CHAR:    s = {ch, 152'h0};
            BODY_CHAR_BS: s = {ch, BS_CODE, 144'h0};
            default:      s = {ch, ESC_CODE, "&a-1C", ESC_CODE, "&a+", d, "H",
                               ch, ESC_CODE, "&a-", d, "H"};
        endcase
        return s[{5'd19 - idx, 3'b000} +: 8];
    endfunction

endpackage

FILE: rtl/osf_front.sv
// Front end: tracks pending characters and the current font, and issues print commands.
module osf_front
    import osf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic       action,
    input  logic [7:0] data_byte,
    output logic       cmd_push,
    output cmd_t       cmd
);

    font_t      font_reg, font_next;
    phase_t     phase_reg, phase_next;
    logic [7:0] pend_reg, pend_next;
    logic [7:0] mapped;
    esc_t       esc;
    body_t      body;
    logic [7:0] ch;

    function automatic esc_t font_escape(font_t want, font_t cur, cfg_t c);
        esc_t e;
        if (want == cur)
        begin
            e = ESC_NONE;
        end
        else
        begin
            unique case (want)
                FONT_ITALIC: e = (c.cartridge_present && !c.landscape) ?
                                 ESC_ITALIC_CART : ESC_ITALIC_PLAIN;
                FONT_BOLD:   e = c.cartridge_present ? ESC_BOLD_CART : ESC_BOLD_PLAIN;
                default:     e = !c.cartridge_present ? ESC_ROMAN_PLAIN :
                                 (c.landscape ? ESC_ROMAN_CART_LAND : ESC_ROMAN_CART);
            endcase
        end
        return e;
    endfunction

    always_comb
    begin
        if (data_byte == APOSTROPHE)
        begin
            mapped = cfg.slanted_apostrophe ? SLANTED_APOS : APOSTROPHE;
        end
        else if (data_byte == BACKQUOTE)
        begin
            mapped = GRAVE_ACCENT;
        end
        else
        begin
            mapped = data_byte;
        end
    end

    always_comb
    begin
        font_next  = font_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        esc        = ESC_NONE;
        body       = BODY_CHAR;
        ch         = pend_reg;
        cmd_push   = 1'b0;
        if (accept && action)
        begin
            unique case (phase_reg)
                PH_CHAR, PH_CHAR_BS:
                begin
                    cmd_push = 1'b1;
                    body     = (phase_reg == PH_CHAR_BS) ? BODY_CHAR_BS : BODY_CHAR;
                    // An underscore goes out as written, without touching the font.
                    if (pend_reg != UNDERSCORE)
                    begin
                        esc       = font_escape(FONT_ROMAN, font_reg, cfg);
                        font_next = FONT_ROMAN;
                    end
                end
                default:
                begin
                end
            endcase
            phase_next = PH_NONE;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_CHAR:
                begin
                    if (mapped == BS_CODE)
                    begin
                        phase_next = PH_CHAR_BS;
                    end
                    else
                    begin
                        cmd_push  = 1'b1;
                        pend_next = mapped;
                        if (pend_reg != UNDERSCORE)
                        begin
                            esc       = font_escape(FONT_ROMAN, font_reg, cfg);
                            font_next = FONT_ROMAN;
                        end
                    end
                end
                PH_CHAR_BS:
                begin
                    cmd_push = 1'b1;
                    if (pend_reg == UNDERSCORE)
                    begin
                        esc        = font_escape(FONT_ITALIC, font_reg, cfg);
                        font_next  = FONT_ITALIC;
                        ch         = mapped;
                        phase_next = PH_NONE;
                    end
                    else if (mapped == pend_reg)
                    begin
                        if (!cfg.cartridge_present || cfg.landscape)
                        begin
                            body = cfg.landscape ? BODY_STRIKE_LAND : BODY_STRIKE_PORT;
                        end
                        else
                        begin
                            esc       = font_escape(FONT_BOLD, font_reg, cfg);
                            font_next = FONT_BOLD;
                        end
                        phase_next = PH_NONE;
                    end
                    else
                    begin
                        // Backspace over a different char: print the held char and the
                        // backspace, then hold the new char.
                        esc        = font_escape(FONT_ROMAN, font_reg, cfg);
                        font_next  = FONT_ROMAN;
                        body       = BODY_CHAR_BS;
                        pend_next  = mapped;
                        phase_next = PH_CHAR;
                    end
                end
                default:
                begin
                    pend_next  = mapped;
                    phase_next = PH_CHAR;
                end
            endcase
        end
    end

    assign cmd = '{esc: esc, body: body, ch: ch};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_reg  <= FONT_ROMAN;
            phase_reg <= PH_NONE;
            pend_reg  <= 8'h00;
        end
        else
        begin
            font_reg  <= font_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

    a_escape_changes_font: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd.esc != ESC_NONE) |=> (font_reg != $past(font_reg)))
        else $error("font escape issued without a font change");

endmodule

FILE: rtl/osf_cmd_queue.sv
// Short command queue between the front end and the byte sequencer.
module osf_cmd_queue
    import osf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              wr_en, rd_en;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = pop && head_valid;

    always_comb
    begin
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");

endmodule

FILE: rtl/osf_back.sv
// Back end: expands each command into escape and text bytes, one byte per cycle while pop is high.
module osf_back
    import osf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last
);

    bk_state_t  state_reg, state_next;
    cmd_t       cmd_reg, cmd_next;
    logic [4:0] idx_reg, idx_next;
    logic       load;

    assign empty    = (state_reg == BK_IDLE);
    assign last     = (state_reg == BK_BODY) && (idx_reg == body_last_idx(cmd_reg.body));
    assign out_byte = (state_reg == BK_ESC) ? esc_byte(cmd_reg.esc, idx_reg[3:0]) :
                      body_byte(cmd_reg.body, idx_reg, cmd_reg.ch);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        load       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                load = q_valid;
            end
            BK_ESC:
            begin
                if (pop)
                begin
                    if (idx_reg[3:0] == esc_last_idx(cmd_reg.esc))
                    begin
                        state_next = BK_BODY;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            BK_BODY:
            begin
                if (pop)
                begin
                    if (last)
                    begin
                        // Take the next command straight away so bytes flow without a gap.
                        load       = q_valid;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        if (load)
        begin
            cmd_next   = q_cmd;
            idx_next   = '0;
            state_next = (q_cmd.esc != ESC_NONE) ? BK_ESC : BK_BODY;
        end
        q_pop = load;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    a_body_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_BODY) |-> (idx_reg <= body_last_idx(cmd_reg.body)))
        else $error("body index ran past the end of the command");

    a_esc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ESC) |->
            (cmd_reg.esc != ESC_NONE && idx_reg <= {1'b0, esc_last_idx(cmd_reg.esc)}))
        else $error("escape run out of range");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && last && q_valid) |=> !empty)
        else $error("sequencer went idle with a command waiting");

endmodule

FILE: rtl/overstrike_to_printer_font_filter.sv
// Top level of the overstrike-to-printer-font filter: configuration registers and wiring.
//
// Input channel: present action and data_byte with push; a request is taken at a
// clock edge where push is high and full is low. A text byte may be held back until
// the following byte shows whether it starts an overstrike; a flush request
// (action = 1) releases whatever is held.
// Result channel: while empty is low, out_byte and last show the oldest waiting
// byte; pop takes it. last marks the final byte caused by one request; a request
// may cause no byte at all, or up to twenty.
// Configuration: cfg_valid with cfg_index and cfg_data writes landscape (0),
// cartridge_present (1) or slanted_apostrophe (2); cfg_ready is always high.
// With the sequencer idle, the command for a request is written into the queue when the
// request is taken, then loaded into the sequencer, which drives its first byte out.
// Throughput: while pop is high the sequencer gives one byte per cycle; a request is taken
// every cycle while the four-entry command queue has room, so requests that cause one byte
// each flow at one per cycle and long escape runs hold the input back.
// If the receiver stops popping, the current byte holds, the queue fills and full rises.
// Reset sets the roman font, nothing held, landscape off, cartridge fitted and
// plain apostrophes.
module overstrike_to_printer_font_filter
    import osf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 action,
    input  logic [7:0]           data_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           out_byte,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    cfg_t cfg_reg;
    logic accept;
    logic cmd_push;
    cmd_t cmd;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t q_cmd;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{landscape: 1'b0, cartridge_present: 1'b1, slanted_apostrophe: 1'b0};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LANDSCAPE: cfg_reg.landscape          <= cfg_data;
                CFG_CARTRIDGE: cfg_reg.cartridge_present  <= cfg_data;
                CFG_SLANTED:   cfg_reg.slanted_apostrophe <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    osf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .action    (action),
        .data_byte (data_byte),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    osf_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    osf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule

FILE: sim/tb_overstrike_to_printer_font_filter.sv
// Self-checking testbench for the overstrike font filter, with a predictor and a random request driver.
module tb_overstrike_to_printer_font_filter;
    import osf_pkg::*;

    localparam logic ACT_TEXT    = 1'b0;
    localparam logic ACT_FLUSH   = 1'b1;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_TAIL    = 12;
    localparam int MAX_REPORTS   = 30;
    localparam int PHASE_ITEMS   = 52;
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_BACKLOG  = 16;
    // Each entry is {landscape, cartridge_present, slanted_apostrophe}.
    localparam logic [2:0] MODE_TABLE [8] = '{3'b010, 3'b111, 3'b001, 3'b100,
                                              3'b000, 3'b110, 3'b011, 3'b101};

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } text_request_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } printer_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 action = 1'b0;
    logic [7:0]           data_byte = 8'h00;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [7:0]           out_byte;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LANDSCAPE;
    logic                 cfg_data = 1'b0;

    text_request_t pending_requests[$];
    printer_byte_t bytes_due[$];
    logic [7:0]    step_out[$];

    // Predictor state and its copy of the registers.
    font_t      pr_font = FONT_ROMAN;
    logic [7:0] pr_held = 8'h00;
    phase_t     pr_phase = PH_NONE;
    logic       reg_land = 1'b0;
    logic       reg_cart = 1'b1;
    logic       reg_slant = 1'b0;

    int  cycle_count = 0;
    int  requests_queued = 0;
    int  requests_taken = 0;
    int  bytes_checked = 0;
    int  full_stalls = 0;
    int  holds_done = 0;
    int  mismatches = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    logic idle_on = 1'b1;
    logic rx_hold = 1'b0;

    overstrike_to_printer_font_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .data_byte (data_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("overstrike_to_printer_font_filter verification failed");
            $finish;
        end
    end

    function automatic void put_esc(string s);
        step_out.push_back(ESC_CODE);
        for (int i = 0; i < s.len(); i++)
            step_out.push_back(s[i]);
    endfunction

    function automatic void switch_font(font_t want);
        if (pr_font != want)
        begin
            case (want)
                FONT_ITALIC:
                    if (reg_cart && !reg_land)
                        put_esc("(s1s-1B");
                    else
                    begin
                        put_esc("(s0B");
                        put_esc("&dD");
                    end
                FONT_BOLD:
                begin
                    put_esc("&d@");
                    put_esc("(s4B");
                    if (reg_cart)
                        put_esc("(s0s1B");
                end
                default:
                    if (reg_cart)
                    begin
                        put_esc("(s0s0B");
                        if (reg_land)
                            put_esc("&d@");
                    end
                    else
                    begin
                        put_esc("(s0B");
                        put_esc("&d@");
                    end
            endcase
            pr_font = want;
        end
    endfunction

    function automatic void send_roman(logic [7:0] c);
        // An underscore on its own never changes the font.
        if (c != UNDERSCORE)
            switch_font(FONT_ROMAN);
        step_out.push_back(c);
    endfunction

    function automatic void predict_printer_bytes(logic act, logic [7:0] raw);
        logic [7:0] b;
        logic [7:0] p;
        b = raw;
        p = pr_held;
        step_out.delete();
        if (act == ACT_FLUSH)
        begin
            if (pr_phase == PH_CHAR)
                send_roman(p);
            else if (pr_phase == PH_CHAR_BS)
            begin
                if (p != UNDERSCORE)
                    switch_font(FONT_ROMAN);
                step_out.push_back(p);
                step_out.push_back(BS_CODE);
            end
            pr_phase = PH_NONE;
        end
        else
        begin
            if (b == APOSTROPHE)
                b = reg_slant ? SLANTED_APOS : APOSTROPHE;
            else if (b == BACKQUOTE)
                b = GRAVE_ACCENT;
            case (pr_phase)
                PH_CHAR:
                    if (b == BS_CODE)
                        pr_phase = PH_CHAR_BS;
                    else
                    begin
                        send_roman(p);
                        pr_held = b;
                    end
                PH_CHAR_BS:
                    if (p == UNDERSCORE)
                    begin
                        switch_font(FONT_ITALIC);
                        step_out.push_back(b);
                        pr_phase = PH_NONE;
                    end
                    else if (b == p)
                    begin
                        // Without a true bold font the char is struck twice, nudged right.
                        if (!reg_cart || reg_land)
                        begin
                            step_out.push_back(p);
                            put_esc("&a-1C");
                            put_esc(reg_land ? "&a+7H" : "&a+8H");
                            step_out.push_back(p);
                            put_esc(reg_land ? "&a-7H" : "&a-8H");
                        end
                        else
                        begin
                            switch_font(FONT_BOLD);
                            step_out.push_back(p);
                        end
                        pr_phase = PH_NONE;
                    end
                    else
                    begin
                        switch_font(FONT_ROMAN);
                        step_out.push_back(p);
                        step_out.push_back(BS_CODE);
                        pr_held = b;
                        pr_phase = PH_CHAR;
                    end
                default:
                begin
                    pr_held = b;
                    pr_phase = PH_CHAR;
                end
            endcase
        end
        foreach (step_out[i])
            bytes_due.push_back('{step_out[i], i == step_out.size() - 1});
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s at byte %0d: got %h, expected %h",
                     what, bytes_checked, got, want);
    endtask

    // Requests and printer bytes are both taken at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && full)
                full_stalls++;
            if (push && !full)
            begin
                predict_printer_bytes(action, data_byte);
                void'(pending_requests.pop_front());
                requests_taken++;
            end
            if (pop && !empty)
            begin
                if (bytes_due.size() == 0)
                    report_mismatch("unexpected byte", out_byte, 8'h00);
                else
                begin
                    if (out_byte !== bytes_due[0].data)
                        report_mismatch("out_byte", out_byte, bytes_due[0].data);
                    if (last !== bytes_due[0].fin)
                        report_mismatch("last", {7'd0, last}, {7'd0, bytes_due[0].fin});
                    void'(bytes_due.pop_front());
                end
                bytes_checked++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (tx_gap == 0 && idle_on && $urandom_range(0, 11) == 0)
            tx_gap = $urandom_range(1, 14);
        if (tx_gap != 0 || !rst_n)
        begin
            if (tx_gap != 0)
                tx_gap--;
            push <= 1'b0;
        end
        else if (pending_requests.size() != 0)
        begin
            push      <= 1'b1;
            action    <= pending_requests[0].act;
            data_byte <= pending_requests[0].data;
        end
        else
            push <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (rx_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
            rx_gap = $urandom_range(1, 14);
        if (rx_gap != 0)
        begin
            rx_gap--;
            pop <= 1'b0;
        end
        else
            pop <= !rx_hold;
    end

    // The receiver stops for a long stretch so that the block fills and raises full.
    // Each hold starts while plenty of requests are still waiting to be sent.
    initial
    begin
        for (int k = 0; k < 2; k++)
        begin
            while (requests_taken < 100 + 200 * k ||
                   pending_requests.size() < HOLD_BACKLOG)
                @(negedge clk);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            @(negedge clk);
            rx_hold = 1'b0;
            holds_done++;
        end
    end

    function automatic void add_request(logic act, logic [7:0] data);
        pending_requests.push_back('{act, data});
        requests_queued++;
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 2) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: return UNDERSCORE;
            1: return APOSTROPHE;
            2: return BACKQUOTE;
            3: return BS_CODE;
            4: return 8'h00;
            default: return 8'h61;
        endcase
    endfunction

    // Mostly well-formed overstrike sequences with random chars, some noise.
    task automatic queue_random_requests(int n);
        int start;
        int kind;
        logic [7:0] c;
        logic [7:0] d;
        start = requests_queued;
        while (requests_queued - start < n)
        begin
            kind = $urandom_range(0, 15);
            c = pick_char();
            d = pick_char();
            if (kind < 4)
                add_request(ACT_TEXT, c);
            else if (kind < 6)
            begin
                add_request(ACT_TEXT, UNDERSCORE);
                add_request(ACT_TEXT, BS_CODE);
                add_request(ACT_TEXT, c);
            end
            else if (kind < 8)
            begin
                add_request(ACT_TEXT, c);
                add_request(ACT_TEXT, BS_CODE);
                add_request(ACT_TEXT, c);
            end
            else if (kind == 8)
            begin
                add_request(ACT_TEXT, c);
                add_request(ACT_TEXT, BS_CODE);
                add_request(ACT_TEXT, d);
            end
            else if (kind == 9)
                add_request(ACT_FLUSH, 8'($urandom_range(0, 255)));
            else if (kind == 10)
            begin
                add_request(ACT_TEXT, c);
                add_request(ACT_TEXT, BS_CODE);
                add_request(ACT_FLUSH, d);
            end
            else if (kind == 11)
            begin
                c = $urandom_range(0, 1) ? APOSTROPHE : BACKQUOTE;
                add_request(ACT_TEXT, c);
                add_request(ACT_TEXT, BS_CODE);
                add_request(ACT_TEXT, c);
            end
            else
                add_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LANDSCAPE: reg_land = val;
            CFG_CARTRIDGE: reg_cart = val;
            default:       reg_slant = val;
        endcase
    endtask

    task automatic apply_mode(logic [2:0] mode);
        write_reg(CFG_LANDSCAPE, mode[2]);
        write_reg(CFG_CARTRIDGE, mode[1]);
        write_reg(CFG_SLANTED, mode[0]);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Some requests cause no byte, so the wait runs on for a tail once the queue is dry.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || bytes_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        apply_mode(MODE_TABLE[0]);
        add_request(ACT_FLUSH, 8'hFF);
        add_request(ACT_TEXT, 8'h00);
        add_request(ACT_TEXT, 8'hFF);
        add_request(ACT_TEXT, UNDERSCORE);
        add_request(ACT_TEXT, BS_CODE);
        add_request(ACT_TEXT, 8'h61);
        add_request(ACT_TEXT, 8'h62);
        add_request(ACT_TEXT, BS_CODE);
        add_request(ACT_TEXT, 8'h62);
        // The bold font must survive the end of the line.
        add_request(ACT_FLUSH, 8'h00);
        add_request(ACT_TEXT, 8'h63);
        add_request(ACT_TEXT, BS_CODE);
        add_request(ACT_TEXT, 8'h64);
        add_request(ACT_TEXT, UNDERSCORE);
        add_request(ACT_TEXT, 8'h65);
        add_request(ACT_TEXT, APOSTROPHE);
        add_request(ACT_TEXT, BACKQUOTE);
        add_request(ACT_FLUSH, 8'h5A);
        add_request(ACT_TEXT, UNDERSCORE);
        add_request(ACT_TEXT, BS_CODE);
        add_request(ACT_FLUSH, 8'hA5);
        add_request(ACT_TEXT, 8'h78);
        add_request(ACT_TEXT, BS_CODE);
        add_request(ACT_FLUSH, 8'h00);
        wait_drained();

        foreach (MODE_TABLE[m])
        begin
            if (m == $size(MODE_TABLE) - 1)
                idle_on = 1'b0;
            apply_mode(MODE_TABLE[m]);
            queue_random_requests(PHASE_ITEMS / 2);
            // The sender stops here until every byte so far has come out.
            wait_drained();
            queue_random_requests(PHASE_ITEMS / 2);
            if (m == $size(MODE_TABLE) - 1)
                add_request(ACT_FLUSH, 8'h00);
            wait_drained();
        end

        $display("Run covered %0d requests and %0d printer bytes over %0d register modes.",
                 requests_taken, bytes_checked, $size(MODE_TABLE));
        $display("Receiver held off %0d times; the input was held back on %0d cycles.",
                 holds_done, full_stalls);
        if (mismatches == 0)
            $display("overstrike_to_printer_font_filter verification clean");
        else
            $display("overstrike_to_printer_font_filter verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/osf_pkg.sv
rtl/osf_front.sv
rtl/osf_cmd_queue.sv
rtl/osf_back.sv
rtl/overstrike_to_printer_font_filter.sv
sim/tb_overstrike_to_printer_font_filter.sv
